### rtl/core/vvr_pkg.sv
// shared types and constants for the voice volume ramp block
package vvr_pkg;

    localparam int LEVEL_W  = 7;
    localparam int STEP_W   = 8;
    localparam int DUR_W    = 15;
    localparam int CNT_W    = 16;
    localparam int VOL_W    = 14;
    localparam int ACC_W    = 28;
    localparam int OPB_W    = 15;
    localparam int RCP_W    = 29;
    localparam int RCP_SHIFT = 42;
    localparam int DIV_STEPS = 28;
    localparam int DIV_CNT_W = 5;

    localparam logic [VOL_W-1:0]   SCALE_MUL  = 14'h3FFF;
    // ceil(2^42 / 0x3f01), exact quotient for any dividend below 2^28
    localparam logic [RCP_W-1:0]   SCALE_RCP  = 29'd272679430;
    localparam logic [LEVEL_W-1:0] PAN_CENTER = 7'h40;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 7'd127;
    localparam int                 PAN_SHIFT  = 6;

    localparam logic ACT_ARM  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic REG_BANK = 1'b0;
    localparam logic REG_MONO = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_ARM,
        S_MUL_A,
        S_MUL_B,
        S_DIV_A,
        S_MUL_C,
        S_MUL_D,
        S_DIV_B,
        S_PAN,
        S_FINISH,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_RCP
    } alu_op_t;

    typedef struct packed {
        logic               start;
        alu_op_t            op;
        logic [ACC_W-1:0]   a;
        logic [OPB_W-1:0]   b;
    } alu_req_t;

    typedef struct packed {
        logic               done;
        logic [ACC_W-1:0]   result;
    } alu_rsp_t;

    typedef struct packed {
        logic               active;
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] target;
        logic [STEP_W-1:0]  step;
        logic [DUR_W-1:0]   reload;
        logic [CNT_W-1:0]   countdown;
    } voice_entry_t;

endpackage

### rtl/core/vvr_alu.sv
// shared multiply and bit-serial divide unit
module vvr_alu
    import vvr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [ACC_W-1:0]     q_reg;
    logic [OPB_W-1:0]     rem_reg;
    logic [OPB_W-1:0]     div_reg;

    logic [OPB_W:0]                 trial;
    logic                           ge;
    logic [OPB_W:0]                 diff;
    logic [RCP_W-1:0]               mul_b;
    logic [ACC_W+RCP_W-1:0]         prod;

    assign trial = {rem_reg, q_reg[ACC_W-1]};
    assign ge    = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};
    assign mul_b = (req.op == OP_RCP) ? SCALE_RCP : RCP_W'(req.b);
    assign prod  = {{RCP_W{1'b0}}, req.a} * {{ACC_W{1'b0}}, mul_b};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                if (req.op != OP_DIV)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            if (req.op == OP_MUL)
            begin
                q_reg <= prod[ACC_W-1:0];
            end
            else if (req.op == OP_RCP)
            begin
                q_reg <= ACC_W'(prod[ACC_W+RCP_W-1:RCP_SHIFT]);
            end
            else
            begin
                q_reg   <= req.a;
                rem_reg <= '0;
                div_reg <= req.b;
            end
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[ACC_W-2:0], ge};
            rem_reg <= ge ? diff[OPB_W-1:0] : trial[OPB_W-1:0];
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = q_reg;

endmodule

### rtl/core/vvr_store.sv
// per-voice ramp state memory with valid bits
module vvr_store
    import vvr_pkg::*;
#(
    parameter int VOICES = 24,
    parameter int IDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output voice_entry_t     rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  voice_entry_t     wr_data
);

    voice_entry_t      mem [VOICES];
    voice_entry_t      rd_reg;
    logic              rd_valid_reg;
    logic [VOICES-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_reg : '0;

endmodule

### rtl/core/vvr_ctrl.sv
// sequencer and datapath registers for arm and tick requests
module vvr_ctrl
    import vvr_pkg::*;
#(
    parameter int VOICES = 24,
    parameter int IDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                action,
    input  logic [4:0]          voice,
    input  logic [LEVEL_W-1:0]  start_level,
    input  logic [LEVEL_W-1:0]  end_level,
    input  logic [DUR_W-1:0]    duration,
    input  logic [LEVEL_W-1:0]  master_volume,
    input  logic [LEVEL_W-1:0]  channel_volume,
    input  logic [LEVEL_W-1:0]  pan,
    input  logic [LEVEL_W-1:0]  master_pan,
    input  logic [LEVEL_W-1:0]  extra_pan,
    input  logic [LEVEL_W-1:0]  bank_volume,
    input  logic                mono_mode,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [4:0]          voice_out,
    output logic                updated,
    output logic [VOL_W-1:0]    left_volume,
    output logic [VOL_W-1:0]    right_volume,
    output logic [LEVEL_W-1:0]  current_level,
    output logic                ramp_active,
    output logic                rejected,
    output logic                st_rd_en,
    output logic [IDX_W-1:0]    st_rd_addr,
    input  voice_entry_t        st_rd_data,
    output logic                st_wr_en,
    output logic [IDX_W-1:0]    st_wr_addr,
    output voice_entry_t        st_wr_data,
    output alu_req_t            alu_req,
    input  alu_rsp_t            alu_rsp
);

    state_t state_reg, state_next;

    logic               action_reg;
    logic [4:0]         voice_reg;
    logic               in_range_reg;
    logic [LEVEL_W-1:0] sl_reg, el_reg;
    logic [DUR_W-1:0]   dur_reg;
    logic [LEVEL_W-1:0] mvol_reg, cvol_reg, pan_reg, mpan_reg, xpan_reg;

    voice_entry_t       ent_reg, ent_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic               issued_reg, issued_next;
    logic [1:0]         pan_idx_reg, pan_idx_next;
    logic [VOL_W-1:0]   lv_reg, lv_next, rv_reg, rv_next;
    logic               small_reg, small_next;
    logic               up_reg, up_next;
    logic [LEVEL_W-1:0] mag_reg, mag_next;

    logic               updated_reg, updated_next;
    logic               rejected_reg, rejected_next;
    logic [LEVEL_W-1:0] cur_reg, cur_next;
    logic               act_reg, act_next;
    logic [VOL_W-1:0]   left_reg, left_next, right_reg, right_next;

    logic               in_fire;
    logic               in_range_in;
    logic               arm_bad;
    logic               going_up;
    logic [LEVEL_W-1:0] mag;
    voice_entry_t       ent;
    logic signed [8:0]  step_s;
    logic signed [8:0]  sum;
    logic signed [8:0]  tgt_s;
    logic               hit;
    logic [LEVEL_W-1:0] new_level;
    logic               tick_idle;
    logic               tick_wait;
    logic [LEVEL_W-1:0] pan_sel;
    logic               pan_left;
    logic [STEP_W-1:0]  arm_step;
    logic [DUR_W-1:0]   arm_iv;
    voice_entry_t       arm_entry;
    voice_entry_t       dec_entry;
    voice_entry_t       fin_entry;
    logic               alu_active;

    assign in_fire     = in_valid && in_ready;
    assign in_range_in = 32'(voice) < VOICES;

    assign ent       = st_rd_data;
    assign arm_bad   = (sl_reg == el_reg) || (dur_reg == '0);
    assign going_up  = el_reg > sl_reg;
    assign mag       = going_up ? (el_reg - sl_reg) : (sl_reg - el_reg);
    assign step_s    = {ent.step[STEP_W-1], ent.step};
    assign sum       = $signed({2'b00, ent.level}) + step_s;
    assign tgt_s     = $signed({2'b00, ent.target});
    assign hit       = (!step_s[8] && (step_s != '0) && (tgt_s <= sum))
                     || (step_s[8] && (tgt_s >= sum));
    assign tick_idle = !ent.active;
    assign tick_wait = ent.countdown != '0;

    always_comb
    begin
        if (hit)
        begin
            new_level = ent.target;
        end
        else if (sum < 0)
        begin
            new_level = '0;
        end
        else if (sum > $signed({2'b00, LEVEL_MAX}))
        begin
            new_level = LEVEL_MAX;
        end
        else
        begin
            new_level = sum[LEVEL_W-1:0];
        end
    end

    always_comb
    begin
        unique case (pan_idx_reg)
            2'd0:    pan_sel = pan_reg;
            2'd1:    pan_sel = mpan_reg;
            default: pan_sel = xpan_reg;
        endcase
    end
    assign pan_left = pan_sel >= PAN_CENTER;

    always_comb
    begin
        if (small_reg)
        begin
            arm_step = up_reg ? STEP_W'(1) : {STEP_W{1'b1}};
            arm_iv   = alu_rsp.result[DUR_W-1:0];
        end
        else
        begin
            arm_step = up_reg ? alu_rsp.result[STEP_W-1:0]
                              : STEP_W'(-alu_rsp.result[STEP_W-1:0]);
            arm_iv   = '0;
        end
    end

    always_comb
    begin
        arm_entry.active    = 1'b1;
        arm_entry.level     = sl_reg;
        arm_entry.target    = el_reg;
        arm_entry.step      = arm_step;
        arm_entry.reload    = arm_iv;
        arm_entry.countdown = {1'b0, arm_iv};
    end

    always_comb
    begin
        dec_entry           = ent;
        dec_entry.countdown = ent.countdown - 1'b1;
    end

    always_comb
    begin
        fin_entry           = ent_reg;
        fin_entry.countdown = {1'b0, ent_reg.reload};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                priority if (!in_range_reg)
                begin
                    state_next = S_OUT;
                end
                else if (action_reg == ACT_ARM)
                begin
                    state_next = arm_bad ? S_OUT : S_ARM;
                end
                else if (tick_idle || tick_wait)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_MUL_A;
                end
            end
            S_ARM:    if (alu_rsp.done) state_next = S_OUT;
            S_MUL_A:  if (alu_rsp.done) state_next = S_MUL_B;
            S_MUL_B:  if (alu_rsp.done) state_next = S_DIV_A;
            S_DIV_A:  if (alu_rsp.done) state_next = S_MUL_C;
            S_MUL_C:  if (alu_rsp.done) state_next = S_MUL_D;
            S_MUL_D:  if (alu_rsp.done) state_next = S_DIV_B;
            S_DIV_B:  if (alu_rsp.done) state_next = S_PAN;
            S_PAN:
            begin
                if (alu_rsp.done && (pan_idx_reg == 2'd2))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: state_next = S_OUT;
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        st_rd_en    = 1'b0;
        st_wr_en    = 1'b0;
        st_wr_data  = fin_entry;
        alu_active  = 1'b0;
        alu_req.op  = OP_MUL;
        alu_req.a   = acc_reg;
        alu_req.b   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                st_rd_en = in_valid && in_range_in;
            end
            S_EVAL:
            begin
                st_wr_en   = in_range_reg && (action_reg == ACT_TICK)
                             && !tick_idle && tick_wait;
                st_wr_data = dec_entry;
            end
            S_ARM:
            begin
                alu_active = 1'b1;
                alu_req.op = OP_DIV;
                alu_req.a  = small_reg ? ACC_W'(dur_reg) : ACC_W'(mag_reg);
                alu_req.b  = small_reg ? OPB_W'(mag_reg) : OPB_W'(dur_reg);
                st_wr_en   = alu_rsp.done;
                st_wr_data = arm_entry;
            end
            S_MUL_A:
            begin
                alu_active = 1'b1;
                alu_req.a  = ACC_W'(ent_reg.level);
                alu_req.b  = OPB_W'(bank_volume);
            end
            S_MUL_B:
            begin
                alu_active = 1'b1;
                alu_req.b  = OPB_W'(SCALE_MUL);
            end
            S_DIV_A, S_DIV_B:
            begin
                alu_active = 1'b1;
                alu_req.op = OP_RCP;
            end
            S_MUL_C:
            begin
                alu_active = 1'b1;
                alu_req.b  = OPB_W'(mvol_reg);
            end
            S_MUL_D:
            begin
                alu_active = 1'b1;
                alu_req.b  = OPB_W'(cvol_reg);
            end
            S_PAN:
            begin
                alu_active = 1'b1;
                alu_req.a  = pan_left ? ACC_W'(lv_reg) : ACC_W'(rv_reg);
                alu_req.b  = pan_left ? OPB_W'(LEVEL_MAX - pan_sel) : OPB_W'(pan_sel);
            end
            S_FINISH:
            begin
                st_wr_en   = 1'b1;
                st_wr_data = fin_entry;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        alu_req.start = alu_active && !issued_reg;
    end

    assign st_rd_addr = IDX_W'(voice);
    assign st_wr_addr = IDX_W'(voice_reg);

    // datapath
    always_comb
    begin
        ent_next      = ent_reg;
        acc_next      = acc_reg;
        issued_next   = issued_reg;
        pan_idx_next  = pan_idx_reg;
        lv_next       = lv_reg;
        rv_next       = rv_reg;
        small_next    = small_reg;
        up_next       = up_reg;
        mag_next      = mag_reg;
        updated_next  = updated_reg;
        rejected_next = rejected_reg;
        cur_next      = cur_reg;
        act_next      = act_reg;
        left_next     = left_reg;
        right_next    = right_reg;

        if (alu_req.start)
        begin
            issued_next = 1'b1;
        end
        if (alu_rsp.done)
        begin
            issued_next = 1'b0;
            acc_next    = alu_rsp.result;
        end

        unique case (state_reg)
            S_EVAL:
            begin
                updated_next  = 1'b0;
                rejected_next = 1'b0;
                left_next     = '0;
                right_next    = '0;
                cur_next      = ent.level;
                act_next      = ent.active;
                mag_next      = mag;
                up_next       = going_up;
                small_next    = DUR_W'(mag) < dur_reg;
                pan_idx_next  = '0;
                ent_next      = ent;
                ent_next.level  = new_level;
                ent_next.active = !hit;
                priority if (!in_range_reg)
                begin
                    rejected_next = action_reg == ACT_ARM;
                    cur_next      = '0;
                    act_next      = 1'b0;
                end
                else if (action_reg == ACT_ARM)
                begin
                    rejected_next = arm_bad;
                end
                else
                begin
                    rejected_next = 1'b0;
                end
            end
            S_ARM:
            begin
                if (alu_rsp.done)
                begin
                    cur_next = sl_reg;
                    act_next = 1'b1;
                end
            end
            S_DIV_B:
            begin
                if (alu_rsp.done)
                begin
                    lv_next = alu_rsp.result[VOL_W-1:0];
                    rv_next = alu_rsp.result[VOL_W-1:0];
                end
            end
            S_PAN:
            begin
                if (alu_rsp.done)
                begin
                    pan_idx_next = pan_idx_reg + 1'b1;
                    if (pan_left)
                    begin
                        lv_next = alu_rsp.result[PAN_SHIFT +: VOL_W];
                    end
                    else
                    begin
                        rv_next = alu_rsp.result[PAN_SHIFT +: VOL_W];
                    end
                end
            end
            S_FINISH:
            begin
                updated_next = 1'b1;
                cur_next     = ent_reg.level;
                act_next     = ent_reg.active;
                left_next    = lv_reg;
                right_next   = rv_reg;
                if (mono_mode)
                begin
                    if (lv_reg >= rv_reg)
                    begin
                        right_next = lv_reg;
                    end
                    else
                    begin
                        left_next = rv_reg;
                    end
                end
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            issued_reg  <= 1'b0;
            pan_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            issued_reg  <= issued_next;
            pan_idx_reg <= pan_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            action_reg   <= action;
            voice_reg    <= voice;
            in_range_reg <= in_range_in;
            sl_reg       <= start_level;
            el_reg       <= end_level;
            dur_reg      <= duration;
            mvol_reg     <= master_volume;
            cvol_reg     <= channel_volume;
            pan_reg      <= pan;
            mpan_reg     <= master_pan;
            xpan_reg     <= extra_pan;
        end
        ent_reg      <= ent_next;
        acc_reg      <= acc_next;
        lv_reg       <= lv_next;
        rv_reg       <= rv_next;
        small_reg    <= small_next;
        up_reg       <= up_next;
        mag_reg      <= mag_next;
        updated_reg  <= updated_next;
        rejected_reg <= rejected_next;
        cur_reg      <= cur_next;
        act_reg      <= act_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
    end

    assign voice_out     = voice_reg;
    assign updated       = updated_reg;
    assign left_volume   = left_reg;
    assign right_volume  = right_reg;
    assign current_level = cur_reg;
    assign ramp_active   = act_reg;
    assign rejected      = rejected_reg;

endmodule

### rtl/core/voice_volume_ramp_pan.sv
// top level of the per-voice volume ramp with three-stage pan
//
// one request at a time. a tick that only counts down, an idle voice or a
// rejected arm goes straight on to the output handshake; an accepted arm
// runs a divide on the shared arithmetic unit, and a tick that steps the
// level runs the scaling and pan steps on it. the unit's divider
// retires one quotient bit per cycle over 28 bits for the arm, while the
// scaling multiplies, the two scaling divides (done as reciprocal
// multiplies) and the pan stages each use its multiplier.
// registers: bank_volume at 0x0, mono_mode at 0x4
module voice_volume_ramp_pan
    import vvr_pkg::*;
#(
    parameter int VOICES = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                action,
    input  logic [4:0]          voice,
    input  logic [LEVEL_W-1:0]  start_level,
    input  logic [LEVEL_W-1:0]  end_level,
    input  logic [DUR_W-1:0]    duration,
    input  logic [LEVEL_W-1:0]  master_volume,
    input  logic [LEVEL_W-1:0]  channel_volume,
    input  logic [LEVEL_W-1:0]  pan,
    input  logic [LEVEL_W-1:0]  master_pan,
    input  logic [LEVEL_W-1:0]  extra_pan,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [4:0]          voice_out,
    output logic                updated,
    output logic [VOL_W-1:0]    left_volume,
    output logic [VOL_W-1:0]    right_volume,
    output logic [LEVEL_W-1:0]  current_level,
    output logic                ramp_active,
    output logic                rejected
);

    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

    logic [LEVEL_W-1:0] bank_reg;
    logic               mono_reg;
    logic               cfg_wr;
    logic               reg_idx;

    logic               st_rd_en;
    logic [IDX_W-1:0]   st_rd_addr;
    voice_entry_t       st_rd_data;
    logic               st_wr_en;
    logic [IDX_W-1:0]   st_wr_addr;
    voice_entry_t       st_wr_data;
    alu_req_t           alu_req;
    alu_rsp_t           alu_rsp;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg <= LEVEL_MAX;
            mono_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_BANK: bank_reg <= pwdata[LEVEL_W-1:0];
                REG_MONO: mono_reg <= pwdata[0];
                default:  bank_reg <= bank_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_BANK: prdata = {{(32-LEVEL_W){1'b0}}, bank_reg};
            REG_MONO: prdata = {31'b0, mono_reg};
            default:  prdata = '0;
        endcase
    end

    vvr_store #(
        .VOICES (VOICES),
        .IDX_W  (IDX_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data)
    );

    vvr_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    vvr_ctrl #(
        .VOICES (VOICES),
        .IDX_W  (IDX_W)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .voice          (voice),
        .start_level    (start_level),
        .end_level      (end_level),
        .duration       (duration),
        .master_volume  (master_volume),
        .channel_volume (channel_volume),
        .pan            (pan),
        .master_pan     (master_pan),
        .extra_pan      (extra_pan),
        .bank_volume    (bank_reg),
        .mono_mode      (mono_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .voice_out      (voice_out),
        .updated        (updated),
        .left_volume    (left_volume),
        .right_volume   (right_volume),
        .current_level  (current_level),
        .ramp_active    (ramp_active),
        .rejected       (rejected),
        .st_rd_en       (st_rd_en),
        .st_rd_addr     (st_rd_addr),
        .st_rd_data     (st_rd_data),
        .st_wr_en       (st_wr_en),
        .st_wr_addr     (st_wr_addr),
        .st_wr_data     (st_wr_data),
        .alu_req        (alu_req),
        .alu_rsp        (alu_rsp)
    );

endmodule
